FILE: rtl/qgemm_pkg.sv
package qgemm_pkg;

    // Default tile height; the top level hands it down as TILE_ROWS.
    localparam int DEF_TILE_ROWS = 4;
    // Output rows are numbered in two bits, so at most four rows are emitted.
    localparam int MAX_EMIT_ROWS = 4;
    localparam int N_COLS        = 4;

    // Input command codes (s_axis_tuser).
    typedef enum logic [1:0] {
        CMD_BIAS   = 2'd0,
        CMD_ACC    = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACT_OFF   = 3'd0;
    localparam logic [2:0] REG_WGT_OFF   = 3'd1;
    localparam logic [2:0] REG_SCALE_01  = 3'd2;
    localparam logic [2:0] REG_SCALE_23  = 3'd3;
    localparam logic [2:0] REG_SHIFT     = 3'd4;
    localparam logic [2:0] REG_OUT_OFF   = 3'd5;
    localparam logic [2:0] REG_CLAMP_LO  = 3'd6;
    localparam logic [2:0] REG_CLAMP_HI  = 3'd7;

    // Input tdata layout, lowest bit first.
    localparam int IN_TDATA_W = 104;
    localparam int POS_COL    = 0;
    localparam int POS_BIAS   = 2;
    localparam int POS_ACTS   = 34;
    localparam int POS_WGTS   = 66;
    localparam int POS_ROWS   = 98;
    localparam int POS_COLS   = 101;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_bias;
        logic       accumulate;
        logic       start;
        logic       mul;
        logic       rnd;
        logic       pack;
        logic       emit;
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/qgemm_rq.sv
module qgemm_rq
    import qgemm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_mul_en,
    input  logic        i_rnd_en,
    input  logic [31:0] i_acc,
    input  logic [31:0] i_mult,
    input  logic [5:0]  i_shift,
    input  logic [7:0]  i_out_off,
    input  logic [7:0]  i_clamp_lo,
    input  logic [7:0]  i_clamp_hi,
    output logic [7:0]  o_byte
);

    logic signed [65:0] w_prod;
    logic signed [63:0] r_prod;
    logic signed [63:0] w_fl;
    logic        [63:0] w_mask;
    logic        [63:0] w_rem;
    logic        [63:0] w_half;
    logic               w_up;
    logic signed [63:0] r_fl;
    logic               r_up;
    logic signed [63:0] w_q;
    logic        [15:0] w_sat;
    logic        [15:0] w_t16;
    logic        [7:0]  w_b;
    logic        [7:0]  w_bh;

    // Signed accumulator times unsigned multiplier; the product fits in 64 bits.
    assign w_prod = $signed({i_acc[31], i_acc}) * $signed({1'b0, i_mult});

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= w_prod[63:0];
        end
    end

    // Arithmetic shift, with the dropped bits compared against one half.
    assign w_fl   = r_prod >>> i_shift;
    assign w_mask = ~({64{1'b1}} << i_shift);
    assign w_rem  = r_prod & w_mask;
    assign w_half = 64'd1 << (i_shift - 6'd1);
    assign w_up   = (i_shift != 6'd0) &&
                    ((w_rem > w_half) || ((w_rem == w_half) && w_fl[0]));

    always_ff @(posedge i_clk) begin
        if (i_rnd_en) begin
            r_fl <= w_fl;
            r_up <= w_up;
        end
    end

    assign w_q = r_fl + $signed({63'd0, r_up});

    always_comb begin
        if (w_q > 64'sd32767) begin
            w_sat = 16'h7fff;
        end else if (w_q < -64'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_q[15:0];
        end
        // Output offset wraps in 16 bits, then the result saturates to a byte.
        w_t16 = w_sat + {8'd0, i_out_off};
        if (w_t16[15]) begin
            w_b = 8'd0;
        end else if (w_t16 > 16'd255) begin
            w_b = 8'd255;
        end else begin
            w_b = w_t16[7:0];
        end
        w_bh   = (w_b > i_clamp_hi) ? i_clamp_hi : w_b;
        o_byte = (w_bh < i_clamp_lo) ? i_clamp_lo : w_bh;
    end

endmodule

FILE: rtl/qgemm_dp.sv
module qgemm_dp
    import qgemm_pkg::*;
#(
    parameter int TILE_ROWS = DEF_TILE_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [1:0]  i_column_index,
    input  logic [31:0] i_bias_value,
    input  logic [31:0] i_row_activations,
    input  logic [31:0] i_column_weights,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_row_bytes,
    output logic [1:0]  o_row_number,
    output logic        o_last_row
);

    logic [7:0]  r_act_off;
    logic [31:0] r_wgt_off;
    logic [63:0] r_scale_01;
    logic [63:0] r_scale_23;
    logic [5:0]  r_shift;
    logic [7:0]  r_out_off;
    logic [7:0]  r_clamp_lo;
    logic [7:0]  r_clamp_hi;

    logic [31:0] r_acc  [TILE_ROWS][N_COLS];
    logic [31:0] n_acc  [TILE_ROWS][N_COLS];
    logic [31:0] w_view [MAX_EMIT_ROWS][N_COLS];
    logic signed [8:0] w_a [TILE_ROWS];
    logic signed [8:0] w_w [N_COLS];

    logic [31:0] w_mult;
    logic [7:0]  w_byte;
    logic [31:0] r_word;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_row;
    logic        r_out_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_off  <= 8'd0;
            r_wgt_off  <= 32'd0;
            r_scale_01 <= 64'd0;
            r_scale_23 <= 64'd0;
            r_shift    <= 6'd31;
            r_out_off  <= 8'd0;
            r_clamp_lo <= 8'd0;
            r_clamp_hi <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACT_OFF:  r_act_off  <= i_cfg_data[7:0];
                REG_WGT_OFF:  r_wgt_off  <= i_cfg_data[31:0];
                REG_SCALE_01: r_scale_01 <= i_cfg_data;
                REG_SCALE_23: r_scale_23 <= i_cfg_data;
                REG_SHIFT:    r_shift    <= i_cfg_data[5:0];
                REG_OUT_OFF:  r_out_off  <= i_cfg_data[7:0];
                REG_CLAMP_LO: r_clamp_lo <= i_cfg_data[7:0];
                REG_CLAMP_HI: r_clamp_hi <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Zero-point corrected operands; rows past the fourth see activation byte 0.
    for (genvar r = 0; r < TILE_ROWS; r++) begin : g_act
        if (r < MAX_EMIT_ROWS) begin : g_real
            assign w_a[r] = $signed({1'b0, i_row_activations[8*r +: 8]}) -
                            $signed({1'b0, r_act_off});
        end else begin : g_zero
            assign w_a[r] = -$signed({1'b0, r_act_off});
        end
    end

    for (genvar c = 0; c < N_COLS; c++) begin : g_wgt
        assign w_w[c] = $signed({1'b0, i_column_weights[8*c +: 8]}) -
                        $signed({1'b0, r_wgt_off[8*c +: 8]});
    end

    // One multiply-accumulate cell per accumulator.
    for (genvar r = 0; r < TILE_ROWS; r++) begin : g_mac_r
        for (genvar c = 0; c < N_COLS; c++) begin : g_mac_c
            logic signed [17:0] w_p;
            assign w_p = w_a[r] * w_w[c];
            assign n_acc[r][c] = r_acc[r][c] + {{14{w_p[17]}}, w_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                for (int c = 0; c < N_COLS; c++) begin
                    r_acc[r][c] <= 32'd0;
                end
            end
        end else if (i_cmd.load_bias) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                r_acc[r][i_column_index] <= i_bias_value;
            end
        end else if (i_cmd.accumulate) begin
            r_acc <= n_acc;
        end
    end

    // Rows that can be emitted, padded to four for a two-bit row select.
    for (genvar r = 0; r < MAX_EMIT_ROWS; r++) begin : g_view_r
        for (genvar c = 0; c < N_COLS; c++) begin : g_view_c
            if (r < TILE_ROWS) begin : g_real
                assign w_view[r][c] = r_acc[r][c];
            end else begin : g_pad
                assign w_view[r][c] = 32'd0;
            end
        end
    end

    always_comb begin
        case (i_cmd.col)
            2'd0:    w_mult = r_scale_01[31:0];
            2'd1:    w_mult = r_scale_01[63:32];
            2'd2:    w_mult = r_scale_23[31:0];
            default: w_mult = r_scale_23[63:32];
        endcase
    end

    qgemm_rq u_rq (
        .i_clk      (i_clk),
        .i_mul_en   (i_cmd.mul),
        .i_rnd_en   (i_cmd.rnd),
        .i_acc      (w_view[i_cmd.row][i_cmd.col]),
        .i_mult     (w_mult),
        .i_shift    (r_shift),
        .i_out_off  (r_out_off),
        .i_clamp_lo (r_clamp_lo),
        .i_clamp_hi (r_clamp_hi),
        .o_byte     (w_byte)
    );

    // Row word under assembly; unused byte lanes stay zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start || i_cmd.emit) begin
            r_word <= 32'd0;
        end else if (i_cmd.pack) begin
            r_word[8*i_cmd.col +: 8] <= w_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= r_word;
            r_out_row  <= i_cmd.row;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_row_bytes    = r_out_data;
    assign o_row_number   = r_out_row;
    assign o_last_row     = r_out_last;

endmodule

FILE: rtl/qgemm_ctrl.sv
module qgemm_ctrl
    import qgemm_pkg::*;
#(
    parameter int TILE_ROWS = DEF_TILE_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [2:0] i_rows_used,
    input  logic [2:0] i_cols_used,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    localparam int MAX_ROWS = (TILE_ROWS < MAX_EMIT_ROWS) ? TILE_ROWS : MAX_EMIT_ROWS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RND,
        S_PACK,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic [2:0] r_rows;
    logic [2:0] r_cols;
    logic       w_accept;
    t_cmd       w_cmd;
    logic       w_last_col;
    logic       w_last_row;

    function automatic logic [2:0] clamp_count(input logic [2:0] v, input logic [2:0] hi);
        logic [2:0] res;
        res = v;
        if (v == 3'd0) begin
            res = 3'd1;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    assign w_cmd      = t_cmd'(i_command);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_last_col = (({1'b0, r_col} + 3'd1) == r_cols);
    assign w_last_row = (({1'b0, r_row} + 3'd1) == r_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= 2'd0;
            r_col   <= 2'd0;
            r_rows  <= 3'd1;
            r_cols  <= 3'd1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_cmd == CMD_FINISH)) begin
                        r_rows  <= clamp_count(i_rows_used, 3'(MAX_ROWS));
                        r_cols  <= clamp_count(i_cols_used, 3'(N_COLS));
                        r_row   <= 2'd0;
                        r_col   <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_state <= S_PACK;
                end
                S_PACK: begin
                    if (w_last_col) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_col   <= r_col + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_col <= 2'd0;
                        if (w_last_row) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_bias  = w_accept && (w_cmd == CMD_BIAS);
        o_cmd.accumulate = w_accept && (w_cmd == CMD_ACC);
        o_cmd.start      = w_accept && (w_cmd == CMD_FINISH);
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.rnd        = (r_state == S_RND);
        o_cmd.pack       = (r_state == S_PACK);
        o_cmd.emit       = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.row        = r_row;
        o_cmd.col        = r_col;
        o_cmd.last       = w_last_row;
    end

endmodule

FILE: rtl/quantized_gemm_tile_4x4.sv
// Quantized 8-bit GEMM tile with four columns and TILE_ROWS rows. Each input
// beat carries a command in s_axis_tuser: a bias beat preloads one column of
// 32-bit accumulators in every row, an accumulate beat adds one k element (one
// activation byte per row, one weight byte per column, both offset by their
// zero points) into every accumulator with 32-bit wrap, and a finish
// beat requantizes the tile and sends one output beat per used row, with
// tlast on the final row. Bias and accumulate beats leave the block idle, so a
// stream of them is taken at one beat per cycle. A finish beat keeps the block
// busy while every used row is formed, plus any output stall: every output
// byte passes in turn through one shared requantization unit (a 33x32-bit
// multiply, a rounding shift, then offset, saturation and clamping), in the
// multiply, round and pack states, and each finished row waits for the output
// register. The output register lets the next input beat be taken while the
// last row of a run still waits on the master side. Configuration registers
// are written through i_cfg_we / i_cfg_index / i_cfg_data and must only
// change while the block is idle. Accumulators keep their values after a
// finish; only a bias beat overwrites them.
module quantized_gemm_tile_4x4
    import qgemm_pkg::*;
#(
    parameter int TILE_ROWS = DEF_TILE_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0: column_index[2], bias_value[32], row_activations[32],
    // column_weights[32], rows_used[3], cols_used[3].
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // From bit 0: command[2].
    input  logic [1:0]            s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0: row_bytes[32].
    output logic [31:0]           m_axis_tdata,
    // From bit 0: row_number[2].
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller sequences finish runs and gates the datapath strobes.
    qgemm_ctrl #(
        .TILE_ROWS (TILE_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_command   (s_axis_tuser),
        .i_rows_used (s_axis_tdata[POS_ROWS +: 3]),
        .i_cols_used (s_axis_tdata[POS_COLS +: 3]),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the configuration, the accumulator cells, the
    // requantization unit and the output register.
    qgemm_dp #(
        .TILE_ROWS (TILE_ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_column_index    (s_axis_tdata[POS_COL +: 2]),
        .i_bias_value      (s_axis_tdata[POS_BIAS +: 32]),
        .i_row_activations (s_axis_tdata[POS_ACTS +: 32]),
        .i_column_weights  (s_axis_tdata[POS_WGTS +: 32]),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_row_bytes       (m_axis_tdata),
        .o_row_number      (m_axis_tuser),
        .o_last_row        (m_axis_tlast)
    );

    // A finish beat takes the block busy for at least the following cycle.
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_FINISH))
        |=> !s_axis_tready)
        else $error("block accepted a beat right after a finish beat");

    // While a row other than the last one waits, the run is still in progress.
    a_row_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("block idle while a non-final row is pending");

    // After a non-final row is taken, the output is either idle or shows the row numbered one higher.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (!m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser) + 2'd1)))
        else $error("output rows out of order");

endmodule

FILE: tb/sv/qgemm_tile_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both streams of the GEMM tile and keeps a
// shadow copy of the accumulators and registers. Every finish beat turns into
// a list of packed output rows, which are checked in order against the master
// side beats.
module qgemm_tile_checker
    import qgemm_pkg::*;
#(
    parameter int TILE_ROWS = DEF_TILE_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata,
    input  logic [1:0]            m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int                    o_rows_waiting,
    output int                    o_rows_checked,
    output int                    o_mismatches
);

    localparam int EMIT_ROWS = (TILE_ROWS < MAX_EMIT_ROWS) ? TILE_ROWS : MAX_EMIT_ROWS;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] bytes;
        logic        last;
    } t_tile_row;

    logic [31:0] acc_tile [TILE_ROWS][N_COLS];
    logic [7:0]  act_zero;
    logic [31:0] wgt_zero;
    logic [63:0] mult_01;
    logic [63:0] mult_23;
    logic [5:0]  shift_amt;
    logic [7:0]  out_zero;
    logic [7:0]  clamp_lo;
    logic [7:0]  clamp_hi;
    t_tile_row   expected_rows [$];

    initial begin
        o_rows_waiting = 0;
        o_rows_checked = 0;
        o_mismatches   = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_mismatches < 50) begin
            $display("%0d ns: %s", $time, msg);
        end
        o_mismatches++;
    endtask

    // Arithmetic shift right that rounds a tie toward the even neighbor.
    function automatic logic signed [63:0] shift_half_even(input logic signed [63:0] p,
                                                           input logic [5:0] s);
        logic signed [63:0] q;
        logic [63:0]        rem;
        logic [63:0]        half;
        if (s == 6'd0) begin
            return p;
        end
        q    = p >>> s;
        rem  = p & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 6'd1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 64'sd1;
        end
        return q;
    endfunction

    function automatic logic [7:0] requantize(input logic [31:0] acc, input logic [31:0] mult);
        logic signed [63:0] prod;
        logic signed [63:0] v;
        int                 t;
        prod = $signed({{32{acc[31]}}, acc}) * $signed({32'd0, mult});
        v    = shift_half_even(prod, shift_amt);
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        if (v < -64'sd32768) begin
            v = -64'sd32768;
        end
        // The output zero point wraps within 16 bits before the byte saturation.
        t = int'(v) + int'(out_zero);
        if (t > 32767) begin
            t = t - 65536;
        end
        if (t < 0) begin
            t = 0;
        end
        if (t > 255) begin
            t = 255;
        end
        if (t > int'(clamp_hi)) begin
            t = int'(clamp_hi);
        end
        if (t < int'(clamp_lo)) begin
            t = int'(clamp_lo);
        end
        return t[7:0];
    endfunction

    task automatic check_row();
        t_tile_row want;
        if (expected_rows.size() == 0) begin
            report_mismatch($sformatf("output row %0d (%h) with no finish pending",
                                      m_axis_tuser, m_axis_tdata));
        end else begin
            want = expected_rows.pop_front();
            o_rows_checked++;
            if (m_axis_tuser !== want.row) begin
                report_mismatch($sformatf("row number: expected %0d, got %0d",
                                          want.row, m_axis_tuser));
            end
            if (m_axis_tdata !== want.bytes) begin
                report_mismatch($sformatf("row %0d bytes: expected %h, got %h",
                                          want.row, want.bytes, m_axis_tdata));
            end
            if (m_axis_tlast !== want.last) begin
                report_mismatch($sformatf("row %0d last flag: expected %0b, got %0b",
                                          want.row, want.last, m_axis_tlast));
            end
        end
    endtask

    task automatic predict_beat();
        logic [1:0]  col;
        logic [7:0]  abyte;
        logic [31:0] word;
        logic [31:0] mult [N_COLS];
        int          a;
        int          w;
        int          rows;
        int          cols;
        case (s_axis_tuser)
            CMD_BIAS: begin
                col = s_axis_tdata[POS_COL +: 2];
                for (int r = 0; r < TILE_ROWS; r++) begin
                    acc_tile[r][col] = s_axis_tdata[POS_BIAS +: 32];
                end
            end
            CMD_ACC: begin
                // Rows past the fourth see an activation byte of zero.
                for (int r = 0; r < TILE_ROWS; r++) begin
                    abyte = (r < 4) ? s_axis_tdata[POS_ACTS + 8 * (r % 4) +: 8] : 8'd0;
                    a = int'(abyte) - int'(act_zero);
                    for (int c = 0; c < N_COLS; c++) begin
                        w = int'(s_axis_tdata[POS_WGTS + 8 * c +: 8]) - int'(wgt_zero[8 * c +: 8]);
                        acc_tile[r][c] = acc_tile[r][c] + 32'(a * w);
                    end
                end
            end
            CMD_FINISH: begin
                rows = int'(s_axis_tdata[POS_ROWS +: 3]);
                cols = int'(s_axis_tdata[POS_COLS +: 3]);
                if (rows < 1) begin
                    rows = 1;
                end
                if (rows > EMIT_ROWS) begin
                    rows = EMIT_ROWS;
                end
                if (cols < 1) begin
                    cols = 1;
                end
                if (cols > N_COLS) begin
                    cols = N_COLS;
                end
                mult[0] = mult_01[31:0];
                mult[1] = mult_01[63:32];
                mult[2] = mult_23[31:0];
                mult[3] = mult_23[63:32];
                for (int r = 0; r < rows; r++) begin
                    word = '0;
                    for (int c = 0; c < cols; c++) begin
                        word[8 * c +: 8] = requantize(acc_tile[r][c], mult[c]);
                    end
                    expected_rows.push_back('{row: 2'(r), bytes: word, last: (r == rows - 1)});
                end
            end
            default: begin
                // The unused command leaves everything as it is.
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                for (int c = 0; c < N_COLS; c++) begin
                    acc_tile[r][c] = '0;
                end
            end
            act_zero  = '0;
            wgt_zero  = '0;
            mult_01   = '0;
            mult_23   = '0;
            shift_amt = 6'd31;
            out_zero  = '0;
            clamp_lo  = 8'd0;
            clamp_hi  = 8'd255;
            expected_rows.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_row();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ACT_OFF:  act_zero  = i_cfg_data[7:0];
                    REG_WGT_OFF:  wgt_zero  = i_cfg_data[31:0];
                    REG_SCALE_01: mult_01   = i_cfg_data;
                    REG_SCALE_23: mult_23   = i_cfg_data;
                    REG_SHIFT:    shift_amt = i_cfg_data[5:0];
                    REG_OUT_OFF:  out_zero  = i_cfg_data[7:0];
                    REG_CLAMP_LO: clamp_lo  = i_cfg_data[7:0];
                    REG_CLAMP_HI: clamp_hi  = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_beat();
            end
        end
        o_rows_waiting = expected_rows.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Top of the GEMM tile bench. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts every output row from the
// beats it sees accepted and compares them.
module testbench;
    import qgemm_pkg::*;

    // The command code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Cycles to let pass after the last row before touching the registers.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_index;
    logic [63:0]           i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // From bit 0: column_index[2], bias_value[32], row_activations[32],
    // column_weights[32], rows_used[3], cols_used[3].
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    // From bit 0: command[2].
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // From bit 0: row_bytes[32].
    logic [31:0]           m_axis_tdata;
    // From bit 0: row_number[2].
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    int rows_waiting;
    int rows_checked;
    int mismatches;

    // Bookkeeping for the stimulus side.
    int items_sent = 0;
    int settings_count = 0;
    int directed_items;
    bit no_idle = 1'b0;
    int ready_left = 0;
    int ready_pick;

    quantized_gemm_tile_4x4 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    qgemm_tile_checker tile_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .o_rows_waiting (rows_waiting),
        .o_rows_checked (rows_checked),
        .o_mismatches   (mismatches)
    );

    // 2 ns clock.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop. A correct run needs well under a tenth of this time, even
    // with every finish emitting four rows into the longest output stalls.
    initial begin
        #1000000;
        $display("testbench: FAIL");
        $finish;
    end

    // Master side back-pressure. Each choice holds for a run of cycles: long
    // stretches of steady ready, short toggling, and now and then a long stall,
    // so stalls land on every phase of the row sequencer.
    always @(negedge i_clk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 20) begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(20, 60);
            end else if (ready_pick < 65) begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(0, 3);
            end else if (ready_pick < 92) begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(10, 40);
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] random_word();
        logic [127:0] w;
        w = {$urandom(), $urandom(), $urandom(), $urandom()};
        return w[IN_TDATA_W-1:0];
    endfunction

    function automatic logic [31:0] random_scale();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom();
        end
        return $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
    endfunction

    // Offers one beat on the slave side and returns at the falling edge after
    // it was taken. The gap before it is drawn here, so valid is only lowered
    // when time passes before it rises again. Fields that the command does
    // not use carry random bits, which the block has to ignore.
    task automatic send_beat(input logic [1:0] cmd, input logic [IN_TDATA_W-1:0] data);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 55) begin
            gap = 0;
        end else if (pick < 85) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 95) begin
            gap = $urandom_range(4, 8);
        end else begin
            gap = $urandom_range(15, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic load_bias(input logic [1:0] col, input logic [31:0] bias);
        logic [IN_TDATA_W-1:0] data;
        data = random_word();
        data[POS_COL +: 2]   = col;
        data[POS_BIAS +: 32] = bias;
        send_beat(CMD_BIAS, data);
    endtask

    task automatic accumulate(input logic [31:0] acts, input logic [31:0] wgts);
        logic [IN_TDATA_W-1:0] data;
        data = random_word();
        data[POS_ACTS +: 32] = acts;
        data[POS_WGTS +: 32] = wgts;
        send_beat(CMD_ACC, data);
    endtask

    task automatic finish(input logic [2:0] rows, input logic [2:0] cols);
        logic [IN_TDATA_W-1:0] data;
        data = random_word();
        data[POS_ROWS +: 3] = rows;
        data[POS_COLS +: 3] = cols;
        send_beat(CMD_FINISH, data);
    endtask

    // Drops valid and waits for every predicted row to leave the block, then
    // lets the requested number of further cycles pass.
    task automatic drain_results(input int settle);
        s_axis_tvalid <= 1'b0;
        wait (rows_waiting == 0);
        @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Writes all eight registers, one per cycle, once the block is idle.
    task automatic program_regs(input logic [7:0] act_off, input logic [31:0] wgt_off,
                                input logic [63:0] scale_01, input logic [63:0] scale_23,
                                input logic [5:0] shift, input logic [7:0] out_off,
                                input logic [7:0] lo, input logic [7:0] hi);
        logic [63:0] vals [8];
        logic [2:0]  regs [8];
        vals = '{64'(act_off), 64'(wgt_off), scale_01, scale_23,
                 64'(shift), 64'(out_off), 64'(lo), 64'(hi)};
        regs = '{REG_ACT_OFF, REG_WGT_OFF, REG_SCALE_01, REG_SCALE_23,
                 REG_SHIFT, REG_OUT_OFF, REG_CLAMP_LO, REG_CLAMP_HI};
        drain_results(SETTLE_CYCLES);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    // One random tile: mostly a full bias preload, a short k loop and a
    // finish, with partial preloads, ignored commands and repeated finishes
    // mixed in. About a quarter of the tiles are sent without any gaps.
    task automatic run_tile();
        int          n_bias;
        int          k_len;
        logic [31:0] bias;
        no_idle = ($urandom_range(0, 3) == 0);
        n_bias  = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(0, 3);
        for (int i = 0; i < n_bias; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                bias = $urandom_range(0, 20000) - 10000;
            end else begin
                bias = $urandom();
            end
            load_bias((n_bias == 4) ? 2'(i) : 2'($urandom_range(0, 3)), bias);
        end
        k_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 16);
        for (int i = 0; i < k_len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_beat(CMD_UNUSED, random_word());
            end
            accumulate($urandom(), $urandom());
        end
        finish(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 6) == 0) begin
            finish(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        int          target;
        int          waited;
        bit          held_off;
        logic [5:0]  shift;
        logic [7:0]  lo;
        logic [7:0]  hi;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_ACT_OFF;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_BIAS;
        held_off      = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Straight after reset the multipliers are zero, so a finish with
        // both counts at zero must give one row of a single zero byte. The
        // unused command in front of it must leave no trace.
        send_beat(CMD_UNUSED, random_word());
        finish(3'd0, 3'd0);

        // Unit multipliers and no shift: the extreme bias words and a full
        // scale k element push the sums into both saturation limits. The
        // accumulators survive a finish, so the later finishes re-emit them
        // with other row and column counts, including counts above four.
        program_regs(8'd0, 32'd0, {32'd1, 32'd1}, {32'd1, 32'd1}, 6'd0, 8'd0, 8'd0, 8'd255);
        load_bias(2'd0, 32'h7FFF_FFFF);
        load_bias(2'd1, 32'h8000_0000);
        load_bias(2'd2, 32'd0);
        load_bias(2'd3, 32'd100);
        accumulate(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        accumulate(32'h0000_0000, 32'h0000_0000);
        finish(3'd7, 3'd7);
        finish(3'd0, 3'd0);
        send_beat(CMD_UNUSED, random_word());
        finish(3'd2, 3'd3);

        // Every register at its top value, with the clamp bounds crossed: the
        // lower bound wins, so every emitted byte must equal it.
        program_regs(8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     6'd63, 8'hFF, 8'd200, 8'd50);
        load_bias(2'd3, 32'h7FFF_FFFF);
        accumulate(32'h00FF_00FF, 32'hFF00_FF00);
        finish(3'd4, 3'd4);

        // A one bit shift of small sums hits every tie: 0.5, 1.5, 2.5 and
        // -1.5 must round to the even neighbor. Then two columns sit at the
        // positive 16-bit limit, where adding the output offset wraps.
        program_regs(8'd0, 32'd0, {32'd1, 32'd1}, {32'd1, 32'd1}, 6'd1, 8'd10, 8'd0, 8'd255);
        load_bias(2'd0, 32'd1);
        load_bias(2'd1, 32'd3);
        load_bias(2'd2, 32'd5);
        load_bias(2'd3, -32'sd3);
        finish(3'd4, 3'd4);
        load_bias(2'd1, 32'd65534);
        load_bias(2'd2, 32'h7FFF_FFFF);
        finish(3'd1, 3'd4);
        directed_items = items_sent;

        // Random phases, each under its own register setting. In one phase
        // the sender holds off halfway until every pending row is out.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            shift = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(30, 44));
            if ($urandom_range(0, 3) == 0) begin
                lo = 8'($urandom());
                hi = 8'($urandom());
            end else begin
                lo = 8'($urandom_range(0, 100));
                hi = 8'($urandom_range(150, 255));
            end
            program_regs(8'($urandom()), $urandom(), {random_scale(), random_scale()},
                         {random_scale(), random_scale()}, shift, 8'($urandom()), lo, hi);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                run_tile();
                if (phase == 2 && !held_off && items_sent >= target - ITEMS_PER_PHASE / 2) begin
                    no_idle = 1'b0;
                    drain_results(0);
                    held_off = 1'b1;
                end
            end
        end

        // Let the last rows drain, bounded in case the block hangs.
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (rows_waiting != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d command beats (%0d in the directed part) under %0d register settings.",
                 items_sent, directed_items, settings_count);
        $display("Checked %0d output rows; %0d mismatches, %0d rows still outstanding.",
                 rows_checked, mismatches, rows_waiting);
        if (mismatches == 0 && rows_waiting == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/qgemm_pkg.sv
rtl/qgemm_rq.sv
rtl/qgemm_dp.sv
rtl/qgemm_ctrl.sv
rtl/quantized_gemm_tile_4x4.sv
tb/sv/qgemm_tile_checker.sv
tb/sv/testbench.sv
